/* design/hole_fit_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// hole fit allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HFA_AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hfa check failed");

// next-cycle implication, checked outside reset
`define HFA_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hfa check failed");

`endif

/* design/hfa_pkg.sv */
// ----------------------------------------------------------------------------
// hfa_pkg
// shared sizes, codes and command type of the hole fit allocator
// ----------------------------------------------------------------------------
package hfa_pkg;

    localparam int MAX_HOLES   = 64;
    localparam int IDX_W       = $clog2(MAX_HOLES);
    localparam int CNT_W       = $clog2(MAX_HOLES + 1);
    localparam int SIZE_W      = 16;
    localparam int MODE_W      = 2;
    localparam int OUT_IDX_W   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd2;

    localparam logic POLICY_BEST  = 1'b0;
    localparam logic POLICY_FIRST = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_ALLOC
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SIZE_W-1:0] size;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } back_state_t;

endpackage

/* design/hole_fit_allocator_top.sv */
// ----------------------------------------------------------------------------
// hole_fit_allocator_top
// first-fit / best-fit hole allocator with stream ports
// ----------------------------------------------------------------------------
// Beats on s_* carry a mode in s_tuser (0 clear, 1 append hole, 2 allocate,
// 3 ignored) and a size in s_tdata. Only allocate beats produce a result on
// m_*. Beats enter a two-deep command queue and are executed in order by the
// back end, which takes a new command only once the last one is done. A clear
// or an append is done at once from idle. An allocation reads the hole size
// memory once per loaded hole through its single read port, and stops early
// under first fit once a free hole is found. Taken marks live in flip-flops
// and are cleared at once by reset and by a clear beat, so there is no
// clearing pass after reset. The user must write fit_policy (cfg_wdata) only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hole_fit_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // fit_policy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // size_value[15:0]
    input  logic [1:0]  s_tuser,       // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // found[0], hole_index[6:1], granted_size[22:7], zero
);

    import hfa_pkg::*;

    logic                 fit_policy_reg;
    logic                 cmd_valid;
    cmd_t                 cmd;
    logic                 cmd_pop;
    logic                 out_found;
    logic [OUT_IDX_W-1:0] out_idx;
    logic [SIZE_W-1:0]    out_size;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= POLICY_BEST;
        end else if (cfg_we) begin
            fit_policy_reg <= cfg_wdata;
        end
    end

    hfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_size    (s_tdata),
        .s_mode    (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    hfa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fit_policy (fit_policy_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (out_found),
        .out_idx    (out_idx),
        .out_size   (out_size)
    );

    assign m_tdata = {1'b0, out_size, out_idx, out_found};

endmodule

/* design/hfa_ram.sv */
// ----------------------------------------------------------------------------
// hfa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/hfa_front.sv */
// ----------------------------------------------------------------------------
// hfa_front
// accepts input beats, decodes the mode and queues commands for the back end
// ----------------------------------------------------------------------------
module hfa_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hfa_pkg::SIZE_W-1:0]   s_size,
    input  logic [hfa_pkg::MODE_W-1:0]   s_mode,
    output logic                         cmd_valid,
    output hfa_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);

    import hfa_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;
    cmd_t              dec_cmd;
    logic              dec_ok;

    // classify the beat, reserved mode is dropped
    always_comb begin
        dec_cmd.size = s_size;
        dec_cmd.op   = OP_CLEAR;
        dec_ok       = 1'b1;
        case (s_mode)
            MODE_CLEAR:  dec_cmd.op = OP_CLEAR;
            MODE_APPEND: dec_cmd.op = OP_APPEND;
            MODE_ALLOC:  dec_cmd.op = OP_ALLOC;
            default:     dec_ok     = 1'b0;
        endcase
    end

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready && dec_ok;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

/* design/hfa_back.sv */
// ----------------------------------------------------------------------------
// hfa_back
// executes queued commands: table clear, hole append and fit scan
// ----------------------------------------------------------------------------
module hfa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fit_policy,
    input  logic                           cmd_valid,
    input  hfa_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_found,
    output logic [hfa_pkg::OUT_IDX_W-1:0]  out_idx,
    output logic [hfa_pkg::SIZE_W-1:0]     out_size
);

    import hfa_pkg::*;

    back_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MAX_HOLES-1:0] taken_reg, taken_next;
    logic [SIZE_W-1:0]    req_reg, req_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_W-1:0]    pick_size_reg, pick_size_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [SIZE_W-1:0]    out_size_reg, out_size_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [SIZE_W-1:0]    ram_rdata;
    logic                 hit;

    hfa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_HOLES)
    ) u_sizes (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cmd.size),
        .rd_en   (ram_re),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign hit = cmp_valid_reg && !taken_reg[cmp_idx_reg] && (ram_rdata >= req_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        taken_next     = taken_reg;
        req_next       = req_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = issue_reg[IDX_W-1:0];
        have_next      = have_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_size_next  = out_size_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        cmd_pop        = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_CLEAR: begin
                            count_next = '0;
                            taken_next = '0;
                        end
                        OP_APPEND: begin
                            if (count_reg < CNT_W'(MAX_HOLES)) begin
                                ram_we                         = 1'b1;
                                taken_next[count_reg[IDX_W-1:0]] = 1'b0;
                                count_next                     = count_reg + 1'b1;
                            end
                        end
                        OP_ALLOC: begin
                            req_next       = cmd.size;
                            issue_next     = '0;
                            have_next      = 1'b0;
                            pick_next      = '0;
                            pick_size_next = '0;
                            state_next     = BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    if (!have_reg) begin
                        have_next      = 1'b1;
                        pick_next      = cmp_idx_reg;
                        pick_size_next = ram_rdata;
                    end else if (ram_rdata < pick_size_reg) begin
                        pick_next      = cmp_idx_reg;
                        pick_size_next = ram_rdata;
                    end
                end
                if (hit && !have_reg && (fit_policy == POLICY_FIRST)) begin
                    state_next = BK_DONE;
                end else if (issue_reg < count_reg) begin
                    ram_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                end else if (!cmp_valid_reg) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_found_next = have_reg;
                    out_idx_next   = have_reg ? OUT_IDX_W'(pick_reg) : '0;
                    out_size_next  = have_reg ? pick_size_reg : '0;
                    if (have_reg) begin
                        taken_next[pick_reg] = 1'b1;
                    end
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            taken_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            taken_reg     <= taken_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        have_reg      <= have_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_size_reg  <= out_size_next;
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_idx   = out_idx_reg;
    assign out_size  = out_size_reg;

endmodule

/* design/hfa_checker.sv */
// ----------------------------------------------------------------------------
// hfa_checker
// port-level checks of the hole fit allocator result channel
// ----------------------------------------------------------------------------
`include "hole_fit_allocator_top_defines.svh"

module hfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result beat holds
    `HFA_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a miss reports zero index and zero size
    `HFA_AST_IMPL(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[22:1] == 22'd0)

    // pad bit stays clear
    `HFA_AST_IMPL(a_pad_zero, m_tvalid, m_tdata[23] == 1'b0)

endmodule

bind hole_fit_allocator_top hfa_checker u_hfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hole fit allocator testbench
// loads hole tables, clears them and issues allocation requests under both
// fit policies, with random gaps on both streams and one long output stall;
// every grant is checked field by field against an in-bench allocator model
// ----------------------------------------------------------------------------
module tb;
    import hfa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 150;
    localparam int ITEM_TARGET = 950;
    localparam longint TIMEOUT_NS = 64'd600_000 * 12;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size;
    } hole_cmd_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    size;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // size_value[15:0]
    logic [1:0]  s_tuser = '0;     // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // found[0], hole_index[6:1], granted_size[22:7], zero

    // allocator model state
    logic [SIZE_W-1:0] hole_len [MAX_HOLES];
    bit                hole_busy [MAX_HOLES];
    int                hole_cnt = 0;
    logic              fit_policy = POLICY_BEST;

    hole_cmd_t pend_q [$];
    grant_t    grant_q [$];
    hole_cmd_t tx_next;
    grant_t    rx_want;
    int        items_queued = 0;
    int        err_cnt = 0;
    int        grants_seen = 0;
    int        tx_wait = 0;
    int        rx_wait = 0;
    bit        tx_calm = 0;
    bit        rx_calm = 0;
    int        hold_left = 0;
    bit        hold_armed = 1;

    hole_fit_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic void predict_item(logic [MODE_W-1:0] mode, logic [SIZE_W-1:0] sz);
        int pick;
        bit have;
        grant_t g;
        pick = 0;
        have = 0;
        case (mode)
            MODE_CLEAR: begin
                hole_cnt = 0;
                foreach (hole_busy[k]) hole_busy[k] = 0;
            end
            MODE_APPEND: begin
                if (hole_cnt < MAX_HOLES) begin
                    hole_len[hole_cnt] = sz;
                    hole_busy[hole_cnt] = 0;
                    hole_cnt++;
                end
            end
            MODE_ALLOC: begin
                for (int k = 0; k < hole_cnt; k++) begin
                    if (!hole_busy[k] && hole_len[k] >= sz) begin
                        if (!have) begin
                            have = 1;
                            pick = k;
                        end else if (fit_policy == POLICY_BEST && hole_len[k] < hole_len[pick]) begin
                            pick = k;
                        end
                    end
                end
                g = '0;
                if (have) begin
                    hole_busy[pick] = 1;
                    g.found = 1'b1;
                    g.idx = pick[OUT_IDX_W-1:0];
                    g.size = hole_len[pick];
                end
                grant_q.push_back(g);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_cnt < 100)
            $display("mismatch %s: got %0d, expected %0d (grant %0d)", what, got, want,
                     grants_seen);
        err_cnt++;
    endtask

    task automatic push_cmd(logic [MODE_W-1:0] mode, logic [SIZE_W-1:0] sz);
        hole_cmd_t c;
        c.mode = mode;
        c.size = sz;
        pend_q.push_back(c);
        if (mode != MODE_NONE) items_queued++;
    endtask

    function automatic logic [SIZE_W-1:0] rand_size(int span);
        case (span)
            0: return SIZE_W'($urandom_range(0, 7));
            1: return SIZE_W'($urandom_range(0, 255));
            default: return SIZE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // one load-then-request sequence, sometimes on top of the existing table
    task automatic queue_random_burst(bit big);
        int span;
        int n_holes;
        int n_reqs;
        span = $urandom_range(0, 2);
        if (big || $urandom_range(0, 9) != 0)
            push_cmd(MODE_CLEAR, SIZE_W'($urandom_range(0, 65535)));
        n_holes = (big || $urandom_range(0, 19) == 0) ? $urandom_range(60, 68)
                                                     : $urandom_range(1, 12);
        for (int k = 0; k < n_holes; k++) begin
            push_cmd(MODE_APPEND, rand_size(span));
            if ($urandom_range(0, 15) == 0)
                push_cmd(MODE_NONE, SIZE_W'($urandom_range(0, 65535)));
        end
        n_reqs = $urandom_range(1, n_holes + 3);
        for (int k = 0; k < n_reqs; k++) begin
            push_cmd(MODE_ALLOC, rand_size(span));
            if ($urandom_range(0, 15) == 0)
                push_cmd(MODE_NONE, SIZE_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pend_q.size() != 0 || s_tvalid || grant_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_policy(logic val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        fit_policy = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            tx_wait = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_item(s_tuser, s_tdata);
                if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 5);
            end
            if (tx_wait != 0 || pend_q.size() == 0) begin
                if (tx_wait != 0) tx_wait--;
                s_tvalid <= 1'b0;
            end else begin
                tx_next = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= tx_next.mode;
                s_tdata <= tx_next.size;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected beat, m_tdata", int'(m_tdata), 0);
                end else begin
                    rx_want = grant_q.pop_front();
                    if (m_tdata[0] !== rx_want.found)
                        report_mismatch("found", int'(m_tdata[0]), int'(rx_want.found));
                    if (m_tdata[6:1] !== rx_want.idx)
                        report_mismatch("hole_index", int'(m_tdata[6:1]), int'(rx_want.idx));
                    if (m_tdata[22:7] !== rx_want.size)
                        report_mismatch("granted_size", int'(m_tdata[22:7]),
                                        int'(rx_want.size));
                end
                grants_seen <= grants_seen + 1;
                if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // long output stall so the input side backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_armed <= 1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && grants_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 0;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("hole_fit_allocator_top verification failed");
        $finish;
    end

    initial begin
        foreach (hole_busy[k]) hole_busy[k] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // best fit after reset: empty table, ties, zero and full-scale sizes
        push_cmd(MODE_ALLOC, 16'd0);
        push_cmd(MODE_APPEND, 16'd0);
        push_cmd(MODE_APPEND, 16'hFFFF);
        push_cmd(MODE_APPEND, 16'd100);
        push_cmd(MODE_APPEND, 16'd100);
        push_cmd(MODE_APPEND, 16'd50);
        push_cmd(MODE_NONE, 16'hFFFF);
        push_cmd(MODE_ALLOC, 16'hFFFF);
        push_cmd(MODE_ALLOC, 16'd100);
        push_cmd(MODE_ALLOC, 16'd0);
        push_cmd(MODE_ALLOC, 16'd1);
        push_cmd(MODE_ALLOC, 16'd1);
        push_cmd(MODE_ALLOC, 16'd0);
        push_cmd(MODE_CLEAR, 16'hAAAA);
        push_cmd(MODE_ALLOC, 16'd0);
        push_cmd(MODE_APPEND, 16'd7);
        push_cmd(MODE_APPEND, 16'd3);
        push_cmd(MODE_ALLOC, 16'd2);
        wait_drained();

        set_policy(POLICY_FIRST);
        push_cmd(MODE_CLEAR, 16'h5555);
        push_cmd(MODE_APPEND, 16'd9);
        push_cmd(MODE_APPEND, 16'd5);
        push_cmd(MODE_ALLOC, 16'd4);
        push_cmd(MODE_ALLOC, 16'd4);
        queue_random_burst(1);
        while (items_queued < ITEM_TARGET / 4) queue_random_burst(0);
        wait_drained();

        set_policy(POLICY_BEST);
        queue_random_burst(1);
        while (items_queued < ITEM_TARGET / 2) queue_random_burst(0);
        wait_drained();

        set_policy(POLICY_FIRST);
        queue_random_burst(1);
        while (items_queued < 3 * ITEM_TARGET / 4) queue_random_burst(0);
        wait_drained();

        set_policy(POLICY_BEST);
        queue_random_burst(1);
        while (items_queued < ITEM_TARGET) queue_random_burst(0);
        wait_drained();

        if (err_cnt == 0)
            $display("hole_fit_allocator_top verification clean");
        else
            $display("hole_fit_allocator_top verification failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/hfa_pkg.sv
design/hfa_ram.sv
design/hfa_front.sv
design/hfa_back.sv
design/hole_fit_allocator_top.sv
design/hfa_checker.sv
bench/tb.sv
